FILE: rtl/tt_pkg.sv
`timescale 1ns / 1ps

package tt_pkg;

   // request codes
   localparam logic [2:0] REQ_TICK         = 3'd0;
   localparam logic [2:0] REQ_START        = 3'd1;
   localparam logic [2:0] REQ_STOP         = 3'd2;
   localparam logic [2:0] REQ_CONSISTENT   = 3'd3;
   localparam logic [2:0] REQ_INCONSISTENT = 3'd4;

   // register indexes
   localparam logic [1:0] CSR_MIN_INTERVAL  = 2'd0;
   localparam logic [1:0] CSR_MAX_DOUBLINGS = 2'd1;
   localparam logic [1:0] CSR_REDUNDANCY    = 2'd2;

   // register reset values and limits
   localparam logic [15:0] MIN_INTERVAL_RESET  = 16'd8;
   localparam logic [4:0]  MAX_DOUBLINGS_RESET = 5'd4;
   localparam logic [7:0]  REDUNDANCY_RESET    = 8'd1;
   localparam logic [15:0] MIN_INTERVAL_FLOOR  = 16'd2;
   localparam logic [4:0]  MAX_DOUBLINGS_CAP   = 5'd16;
   localparam logic [7:0]  HEARD_MAX           = 8'hFF;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [31:0] random_word;
   } req_item_type;

   typedef struct packed {
      logic        tx_allowed;
      logic [31:0] current_interval;
   } rsp_item_type;

endpackage

FILE: rtl/trickle_timer_core.sv
`timescale 1ns / 1ps
// trickle timer core: one item is handled at a time by a bit-serial remainder unit.
// tick, stop, consistent and inconsistent items finish when accepted, or, when a new interval
// begins, go on through a 32-step remainder for the fire point.
// start items run one 32-step remainder for the interval, then one for the fire point.
// a fire result goes to the output register, or to the hold register while that is full.
// reset (synchronous, active high) stops the timer and loads the register defaults.
module trickle_timer_core
   import tt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_payload,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_payload,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_wdata
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SPAN = 2'd1;
   localparam logic [1:0] S_FIRE = 2'd2;

   logic [1:0]   state_ff, state_in;
   logic [15:0]  min_interval_ff, min_interval_in;
   logic [4:0]   max_doublings_ff, max_doublings_in;
   logic [7:0]   redundancy_ff, redundancy_in;
   logic [31:0]  interval_ff, interval_in;
   logic [31:0]  elapsed_ff, elapsed_in;
   logic [31:0]  fire_point_ff, fire_point_in;
   logic [7:0]   heard_ff, heard_in;
   logic         fired_ff, fired_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_payload_ff, rsp_payload_in;
   logic         hold_ff, hold_in;
   rsp_item_type hold_payload_ff, hold_payload_in;
   logic [31:0]  rnd_ff, rnd_in;
   logic [31:0]  dvd_ff, dvd_in;
   logic [31:0]  rem_ff, rem_in;
   logic [31:0]  dsr_ff, dsr_in;
   logic [4:0]   cnt_ff, cnt_in;

   logic [31:0]  eff_min;
   logic [31:0]  eff_max;
   logic [4:0]   eff_dbl;
   logic [32:0]  shifted;
   logic [32:0]  diff;
   logic [31:0]  rem_next;
   logic [31:0]  tick_count;
   logic [31:0]  span_interval;
   logic         slot_free;
   logic         req_fire;
   rsp_item_type fire_item;

   // register writes only between items, and ahead of a new item
   assign req_ready   = (state_ff == S_IDLE) && !hold_ff && !csr_valid;
   assign csr_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // effective interval limits
   always_comb begin
      eff_min = (min_interval_ff < MIN_INTERVAL_FLOOR) ? {16'd0, MIN_INTERVAL_FLOOR}
                                                       : {16'd0, min_interval_ff};
      eff_dbl = (max_doublings_ff > MAX_DOUBLINGS_CAP) ? MAX_DOUBLINGS_CAP
                                                       : max_doublings_ff;
      eff_max = eff_min << eff_dbl;
   end

   // shared restoring remainder step
   always_comb begin
      shifted  = {rem_ff, dvd_ff[31]};
      diff     = shifted - {1'b0, dsr_ff};
      rem_next = diff[32] ? shifted[31:0] : diff[31:0];
   end

   assign tick_count    = elapsed_ff + 32'd1;
   assign span_interval = eff_min + rem_next;
   assign slot_free     = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in         = state_ff;
      min_interval_in  = min_interval_ff;
      max_doublings_in = max_doublings_ff;
      redundancy_in    = redundancy_ff;
      interval_in      = interval_ff;
      elapsed_in       = elapsed_ff;
      fire_point_in    = fire_point_ff;
      heard_in         = heard_ff;
      fired_in         = fired_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_payload_in   = rsp_payload_ff;
      hold_in          = hold_ff;
      hold_payload_in  = hold_payload_ff;
      rnd_in           = rnd_ff;
      dvd_in           = dvd_ff;
      rem_in           = rem_ff;
      dsr_in           = dsr_ff;
      cnt_in           = cnt_ff;
      req_fire         = 1'b0;
      fire_item.tx_allowed       = (redundancy_ff == 8'd0) || (heard_ff < redundancy_ff);
      fire_item.current_interval = interval_ff;

      // register writes
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MIN_INTERVAL:  min_interval_in  = csr_wdata;
            CSR_MAX_DOUBLINGS: max_doublings_in = csr_wdata[4:0];
            CSR_REDUNDANCY:    redundancy_in    = csr_wdata[7:0];
            default: ;
         endcase
      end

      // pending result moves to the output register
      if (hold_ff && slot_free) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = hold_payload_ff;
         hold_in        = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               rnd_in = req_payload.random_word;
               dvd_in = req_payload.random_word;
               rem_in = 32'd0;
               cnt_in = 5'd0;
               case (req_payload.req_type)
                  REQ_TICK: begin
                     if (interval_ff != 32'd0) begin
                        elapsed_in = tick_count;
                        if (!fired_ff && (tick_count >= fire_point_ff)) begin
                           req_fire = 1'b1;
                           fired_in = 1'b1;
                        end
                        // interval end: double (capped at the maximum) and start a fresh interval
                        if (tick_count >= interval_ff) begin
                           if (interval_ff <= (eff_max >> 1)) begin
                              interval_in = interval_ff << 1;
                           end else begin
                              interval_in = eff_max;
                           end
                           dsr_in     = interval_in >> 1;
                           heard_in   = 8'd0;
                           elapsed_in = 32'd0;
                           fired_in   = 1'b0;
                           state_in   = S_FIRE;
                        end
                     end
                  end
                  REQ_START: begin
                     dsr_in     = eff_max - eff_min + 32'd1;
                     heard_in   = 8'd0;
                     elapsed_in = 32'd0;
                     fired_in   = 1'b0;
                     state_in   = S_SPAN;
                  end
                  REQ_STOP: begin
                     interval_in = 32'd0;
                     elapsed_in  = 32'd0;
                  end
                  REQ_CONSISTENT: begin
                     if (heard_ff < HEARD_MAX) begin
                        heard_in = heard_ff + 8'd1;
                     end
                  end
                  REQ_INCONSISTENT: begin
                     if ((interval_ff != 32'd0) && (interval_ff != eff_min)) begin
                        interval_in = eff_min;
                        dsr_in      = eff_min >> 1;
                        heard_in    = 8'd0;
                        elapsed_in  = 32'd0;
                        fired_in    = 1'b0;
                        state_in    = S_FIRE;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_SPAN: begin
            rem_in = rem_next;
            dvd_in = dvd_ff << 1;
            cnt_in = cnt_ff + 5'd1;
            // last step: interval picked, set up the fire point pick
            if (cnt_ff == 5'd31) begin
               interval_in = span_interval;
               dsr_in      = span_interval >> 1;
               dvd_in      = rnd_ff;
               rem_in      = 32'd0;
               cnt_in      = 5'd0;
               state_in    = S_FIRE;
            end
         end
         S_FIRE: begin
            rem_in = rem_next;
            dvd_in = dvd_ff << 1;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               fire_point_in = (dsr_ff == 32'd0) ? 32'd0 : dsr_ff + rem_next;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // new fire result goes out now or waits in the hold register
      if (req_fire) begin
         if (slot_free) begin
            rsp_valid_in   = 1'b1;
            rsp_payload_in = fire_item;
         end else begin
            hold_in         = 1'b1;
            hold_payload_in = fire_item;
         end
      end
   end

   // control and timer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         min_interval_ff  <= MIN_INTERVAL_RESET;
         max_doublings_ff <= MAX_DOUBLINGS_RESET;
         redundancy_ff    <= REDUNDANCY_RESET;
         interval_ff      <= 32'd0;
         elapsed_ff       <= 32'd0;
         fire_point_ff    <= 32'd0;
         heard_ff         <= 8'd0;
         fired_ff         <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         hold_ff          <= 1'b0;
         cnt_ff           <= 5'd0;
      end else begin
         state_ff         <= state_in;
         min_interval_ff  <= min_interval_in;
         max_doublings_ff <= max_doublings_in;
         redundancy_ff    <= redundancy_in;
         interval_ff      <= interval_in;
         elapsed_ff       <= elapsed_in;
         fire_point_ff    <= fire_point_in;
         heard_ff         <= heard_in;
         fired_ff         <= fired_in;
         rsp_valid_ff     <= rsp_valid_in;
         hold_ff          <= hold_in;
         cnt_ff           <= cnt_in;
      end
   end

   // payload and datapath registers
   always_ff @(posedge clock) begin
      rsp_payload_ff  <= rsp_payload_in;
      hold_payload_ff <= hold_payload_in;
      rnd_ff          <= rnd_in;
      dvd_ff          <= dvd_in;
      rem_ff          <= rem_in;
      dsr_ff          <= dsr_in;
   end

endmodule
